// File: rtl/pst_pkg.sv
// Shared types and constants for the priority sorted task table.
// Holds the table size, entry and command types, and the opcode and status codes.
// Every other file depends on this package.
package pst_pkg;

    // Number of cells in the table.
    localparam int CAPACITY = 32;
    // Width of an entry count (0 to CAPACITY).
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Width of a cell index.
    localparam int IDX_W = $clog2(CAPACITY);

    // Operation codes on the input channel.
    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_LIST_ASC  = 3'd3,
        OP_LIST_DESC = 3'd4
    } opcode_t;

    // Status codes on the result channel.
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // One table entry.
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] prio;
    } entry_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } cell_cmd_t;

endpackage

// File: rtl/pst_cell.sv
// One cell of the sorted table: holds a single entry and its compare logic.
// Shifts toward the back on insert and toward the front on remove.
// Depends on pst_pkg.
module pst_cell (
    input  logic              aclk,
    input  pst_pkg::cell_cmd_t cmd,
    input  logic              occ,
    input  pst_pkg::entry_t   left_entry,
    input  pst_pkg::entry_t   right_entry,
    input  logic              after_left,
    input  logic              seen_in,
    output pst_pkg::entry_t   entry,
    output logic              after_out,
    output logic              seen_out,
    output pst_pkg::entry_t   hit_entry
);

    pst_pkg::entry_t entry_reg;
    pst_pkg::entry_t entry_next;
    logic            match;

    assign entry = entry_reg;

    // The new item belongs at or before this cell when this cell is empty
    // or holds a strictly higher priority; ties stay ahead of the new item.
    assign after_out = !occ || ($signed(entry_reg.prio) > $signed(cmd.item.prio));

    // Id match, carried down the chain so only the first match counts.
    assign match     = occ && (entry_reg.id == cmd.item.id);
    assign seen_out  = seen_in || match;
    assign hit_entry = (match && !seen_in) ? entry_reg : '0;

    // Insert shifts back from the insertion point; remove shifts forward
    // from the first match.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins && after_out) begin
            entry_next = after_left ? left_entry : cmd.item;
        end else if (cmd.rem && seen_out) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/priority_sorted_task_table_top.sv
// Insert, remove and search give a single result beat, registered when the command is accepted.
// Throughput: one insert, remove or search per cycle while results are taken; the chain
// of cells compares and shifts all entries at once.
// A listing gives one result beat per stored entry, paced by the result channel, and blocks input.
// Reset (synchronous, active low) empties the table and clears the result valid flag.
// Depends on pst_pkg and pst_cell.
module priority_sorted_task_table_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [15:0]        s_task_id,
    input  logic signed [15:0] s_task_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [15:0]        m_out_id,
    output logic signed [15:0] m_out_priority,
    output logic               m_last
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                          state_reg;
    logic [pst_pkg::CNT_W-1:0]       count_reg;
    logic [pst_pkg::CNT_W-1:0]       list_cnt_reg;
    logic                            desc_reg;
    logic                            m_valid_reg;
    pst_pkg::status_t                m_status_reg;
    pst_pkg::entry_t                 m_entry_reg;
    logic                            m_last_reg;

    pst_pkg::opcode_t                op;
    pst_pkg::cell_cmd_t              cmd;
    pst_pkg::entry_t                 entry_arr [pst_pkg::CAPACITY];
    pst_pkg::entry_t                 hit_arr   [pst_pkg::CAPACITY];
    logic [pst_pkg::CAPACITY:0]      after_chain;
    logic [pst_pkg::CAPACITY:0]      seen_chain;
    logic [pst_pkg::CAPACITY-1:0]    occ;
    pst_pkg::entry_t                 hit_entry;
    pst_pkg::entry_t                 list_entry;
    logic [pst_pkg::CNT_W-1:0]       list_pos;
    logic [pst_pkg::CNT_W-1:0]       list_cnt_inc;
    logic                            list_done;
    logic                            out_free;
    logic                            out_load;
    logic                            s_acc;
    logic                            full;
    logic                            found;

    // Handshake: input is taken only between listings, when the result
    // register is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_valid && s_ready;
    assign op       = pst_pkg::opcode_t'(s_opcode);

    assign full  = (count_reg == pst_pkg::CNT_W'(pst_pkg::CAPACITY));
    assign found = seen_chain[pst_pkg::CAPACITY];

    // Command broadcast to the cells.
    always_comb begin
        cmd.ins       = s_acc && (op == pst_pkg::OP_INSERT) && !full;
        cmd.rem       = s_acc && (op == pst_pkg::OP_REMOVE) && found;
        cmd.item.id   = s_task_id;
        cmd.item.prio = s_task_priority;
    end

    assign after_chain[0] = 1'b0;
    assign seen_chain[0]  = 1'b0;

    // Row of cells; cell 0 is the front of the table.
    for (genvar i = 0; i < pst_pkg::CAPACITY; i++) begin : g_cell
        pst_pkg::entry_t right_entry;

        assign occ[i] = (pst_pkg::CNT_W'(i) < count_reg);

        if (i == pst_pkg::CAPACITY - 1) begin : g_end
            assign right_entry = '0;
        end else begin : g_mid
            assign right_entry = entry_arr[i+1];
        end

        pst_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occ         (occ[i]),
            .left_entry  ((i == 0) ? cmd.item : entry_arr[(i == 0) ? 0 : i-1]),
            .right_entry (right_entry),
            .after_left  (after_chain[i]),
            .seen_in     (seen_chain[i]),
            .entry       (entry_arr[i]),
            .after_out   (after_chain[i+1]),
            .seen_out    (seen_chain[i+1]),
            .hit_entry   (hit_arr[i])
        );
    end

    // At most one cell reports a first match, so an OR gathers it.
    always_comb begin
        hit_entry = '0;
        for (int k = 0; k < pst_pkg::CAPACITY; k++) begin
            hit_entry = hit_entry | hit_arr[k];
        end
    end

    // Listing position, counted from the front or from the back.
    assign list_pos     = desc_reg ? (count_reg - list_cnt_reg - pst_pkg::CNT_W'(1))
                                   : list_cnt_reg;
    assign list_entry   = entry_arr[list_pos[pst_pkg::IDX_W-1:0]];
    assign list_cnt_inc = list_cnt_reg + pst_pkg::CNT_W'(1);
    assign list_done    = (list_cnt_inc == count_reg);

    // A result beat is loaded for every accepted command except a listing of
    // a non-empty table or an unused opcode, and for every listing step.
    always_comb begin
        out_load = 1'b0;
        if (state_reg == S_LIST) begin
            out_load = out_free;
        end else if (s_acc) begin
            case (op)
                pst_pkg::OP_INSERT, pst_pkg::OP_REMOVE, pst_pkg::OP_SEARCH: begin
                    out_load = 1'b1;
                end
                pst_pkg::OP_LIST_ASC, pst_pkg::OP_LIST_DESC: begin
                    out_load = (count_reg == '0);
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end
    end

    // Control state, entry count and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_cnt_reg <= '0;
            desc_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // The result register takes a new beat or empties once taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        case (op)
                            pst_pkg::OP_INSERT: begin
                                m_status_reg <= full ? pst_pkg::ST_FULL : pst_pkg::ST_DONE;
                                m_entry_reg  <= '0;
                                m_last_reg   <= 1'b1;
                                if (!full) begin
                                    count_reg <= count_reg + pst_pkg::CNT_W'(1);
                                end
                            end
                            pst_pkg::OP_REMOVE: begin
                                m_status_reg <= found ? pst_pkg::ST_DONE
                                                      : pst_pkg::ST_NOT_FOUND;
                                m_entry_reg  <= '0;
                                m_last_reg   <= 1'b1;
                                if (found) begin
                                    count_reg <= count_reg - pst_pkg::CNT_W'(1);
                                end
                            end
                            pst_pkg::OP_SEARCH: begin
                                m_status_reg <= found ? pst_pkg::ST_ENTRY
                                                      : pst_pkg::ST_NOT_FOUND;
                                m_entry_reg  <= hit_entry;
                                m_last_reg   <= 1'b1;
                            end
                            pst_pkg::OP_LIST_ASC, pst_pkg::OP_LIST_DESC: begin
                                if (count_reg == '0) begin
                                    m_status_reg <= pst_pkg::ST_EMPTY;
                                    m_entry_reg  <= '0;
                                    m_last_reg   <= 1'b1;
                                end else begin
                                    state_reg    <= S_LIST;
                                    list_cnt_reg <= '0;
                                    desc_reg     <= (op == pst_pkg::OP_LIST_DESC);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LIST: begin
                    // One entry per beat while the result register drains.
                    if (out_free) begin
                        m_status_reg <= pst_pkg::ST_ENTRY;
                        m_entry_reg  <= list_entry;
                        m_last_reg   <= list_done;
                        list_cnt_reg <= list_cnt_inc;
                        if (list_done) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_id       = m_entry_reg.id;
    assign m_out_priority = m_entry_reg.prio;
    assign m_last         = m_last_reg;

endmodule
